FILE: rtl/gja_pkg.sv
package gja_pkg;

	// default array sizes
	localparam int unsigned MAX_AGENTS_DEF = 16;
	localparam int unsigned MAX_JOBS_DEF   = 16;

	// field widths
	localparam int unsigned REQ_W  = 2;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned COST_W = 24;
	localparam int unsigned POS_W  = 24;

	// configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic [0:0]  REG_LEADER = 1'b0;

	// request codes
	localparam logic [REQ_W-1:0] REQ_JOB  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_COST = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RUN  = 2'd2;

	// run sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEXT,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/gja_req_if.sv
interface gja_req_if;
	import gja_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [IDX_W-1:0]         agent_index;
	logic [IDX_W-1:0]         job_index;
	logic signed [POS_W-1:0]  job_x;
	logic signed [POS_W-1:0]  job_y;
	logic [COST_W-1:0]        cost_value;

	modport source (
		output valid, req_type, agent_index, job_index, job_x, job_y, cost_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, agent_index, job_index, job_x, job_y, cost_value,
		output ready
	);

endinterface

FILE: rtl/gja_res_if.sv
interface gja_res_if;
	import gja_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_agent;
	logic                     has_job;
	logic [IDX_W-1:0]         out_job;
	logic signed [POS_W-1:0]  out_x;
	logic signed [POS_W-1:0]  out_y;
	logic                     last_result;

	modport source (
		output valid, out_agent, has_job, out_job, out_x, out_y, last_result,
		input  ready
	);

	modport sink (
		input  valid, out_agent, has_job, out_job, out_x, out_y, last_result,
		output ready
	);

endinterface

FILE: rtl/gja_ram.sv
module gja_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/greedy_job_assignment.sv
// channel | dir | handshake     | word
// --------+-----+---------------+-------------------------------------------------
// req     | in  | valid / ready | req_type, agent_index, job_index, job_x, job_y,
//         |     |               | cost_value
// res     | out | valid / ready | out_agent, has_job, out_job, out_x, out_y,
//         |     |               | last_result
// apb     | in  | psel/penable  | leader_enable at byte address 0
//
// job and cost entries are taken while idle and leave req ready for the next word.
// a run visits each agent slot up to the last one that reported (all slots when none
// did), then scans the job list and emits one word for each agent that reported: the
// single read port of the cost RAM delivers one cost per cycle.
// emit waits while the output register holds a word that has not been taken.
// arst_n clears control state and marks; the cost RAM needs no clearing pass.
module greedy_job_assignment #(
	parameter int unsigned MAX_AGENTS = gja_pkg::MAX_AGENTS_DEF,
	parameter int unsigned MAX_JOBS   = gja_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gja_req_if.sink                     req,
	gja_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gja_pkg::APB_AW-1:0]  paddr,
	input  logic [gja_pkg::APB_DW-1:0]  pwdata,
	output logic [gja_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import gja_pkg::*;

	localparam int unsigned NCOST = MAX_AGENTS * MAX_JOBS;
	localparam int unsigned CAW   = (NCOST > 1) ? $clog2(NCOST) : 1;
	localparam int unsigned AGW   = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam int unsigned JIW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned JCW   = $clog2(MAX_JOBS + 1);
	localparam logic [AGW-1:0] LAST_AG = AGW'(MAX_AGENTS - 1);

	state_t state_q, state_d;

	logic                  leader_q;
	logic                  round_open_q;
	logic [JCW-1:0]        job_count_q;
	logic [MAX_AGENTS-1:0] agent_present_q;
	logic [NCOST-1:0]      known_q;
	logic [MAX_JOBS-1:0]   job_taken_q;
	logic [POS_W-1:0]      pos_x_q [MAX_JOBS];
	logic [POS_W-1:0]      pos_y_q [MAX_JOBS];

	logic [AGW-1:0]        ag_q;
	logic [JCW-1:0]        k_q;
	logic                  rd_vld_s1;
	logic                  elig_s1;
	logic [JIW-1:0]        k_s1;
	logic                  found_q;
	logic [JIW-1:0]        best_q;
	logic [COST_W-1:0]     best_cost_q;

	logic                  res_valid_q;
	logic [IDX_W-1:0]      out_agent_q;
	logic                  has_job_q;
	logic [IDX_W-1:0]      out_job_q;
	logic [POS_W-1:0]      out_x_q;
	logic [POS_W-1:0]      out_y_q;
	logic                  last_q;

	logic                  acc;
	logic                  job_ok;
	logic                  agent_ok;
	logic                  job_wr;
	logic                  cost_wr;
	logic                  run_go;
	logic                  cfg_wr;
	logic [JCW-1:0]        job_next;
	logic [AGW-1:0]        agent_in;
	logic [JIW-1:0]        job_in;
	logic [CAW-1:0]        wr_addr;
	logic [CAW-1:0]        scan_addr;
	logic [COST_W-1:0]     cost_rd;
	logic                  scan_issue;
	logic                  scan_done;
	logic                  slot_free;
	logic                  emit;
	logic                  better;
	logic [MAX_AGENTS-1:0] above_mask;
	logic                  last_agent;

	// input decode
	always_comb begin
		acc      = req.valid && req.ready;
		job_ok   = 32'(req.job_index) < MAX_JOBS;
		agent_ok = 32'(req.agent_index) < MAX_AGENTS;
		agent_in = AGW'(req.agent_index);
		job_in   = JIW'(req.job_index);
		job_next = JCW'(32'(req.job_index) + 32'd1);
		wr_addr  = CAW'(32'(req.agent_index) * MAX_JOBS + 32'(req.job_index));
		job_wr   = acc && (req.req_type == REQ_JOB) && job_ok;
		cost_wr  = acc && (req.req_type == REQ_COST) && job_ok && agent_ok;
		run_go   = acc && (req.req_type == REQ_RUN) && leader_q && round_open_q;
		cfg_wr   = psel && penable && pwrite && pready &&
			(paddr[APB_AW-1:2] == REG_LEADER);
	end

	// scan and emit conditions
	always_comb begin
		scan_addr  = CAW'(32'(ag_q) * MAX_JOBS + 32'(k_q));
		scan_done  = k_q >= job_count_q;
		slot_free  = !res_valid_q || res.ready;
		better     = rd_vld_s1 && elig_s1 && (!found_q || (cost_rd < best_cost_q));
		for (int i = 0; i < MAX_AGENTS; i++) begin
			above_mask[i] = 32'(i) > 32'(ag_q);
		end
		last_agent = ~|(agent_present_q & above_mask);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_go) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (agent_present_q[ag_q]) state_d = ST_SCAN;
				else if (ag_q == LAST_AG) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_done && !rd_vld_s1) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) state_d = last_agent ? ST_IDLE : ST_NEXT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		scan_issue = (state_q == ST_SCAN) && !scan_done;
		emit       = (state_q == ST_EMIT) && slot_free;
	end

	// cost store
	gja_ram #(
		.WIDTH (COST_W),
		.DEPTH (NCOST)
	) u_cost_ram (
		.clk   (clk),
		.we    (cost_wr),
		.waddr (wr_addr),
		.wdata (req.cost_value),
		.raddr (scan_addr),
		.rdata (cost_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			leader_q        <= 1'b0;
			round_open_q    <= 1'b0;
			job_count_q     <= '0;
			agent_present_q <= '0;
			known_q         <= '0;
			job_taken_q     <= '0;
			ag_q            <= '0;
			k_q             <= '0;
			rd_vld_s1       <= 1'b0;
			found_q         <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				leader_q <= pwdata[0];
			end
			// job entry, slot 0 opens a round
			if (job_wr) begin
				if (req.job_index == '0) begin
					known_q         <= '0;
					agent_present_q <= '0;
					round_open_q    <= 1'b1;
					job_count_q     <= job_next;
				end else if (job_next > job_count_q) begin
					job_count_q <= job_next;
				end
			end
			if (cost_wr) begin
				known_q[wr_addr]          <= 1'b1;
				agent_present_q[agent_in] <= 1'b1;
			end
			if (run_go) begin
				round_open_q <= 1'b0;
				job_taken_q  <= '0;
				ag_q         <= '0;
			end
			// agent step
			if (state_q == ST_NEXT) begin
				if (agent_present_q[ag_q]) begin
					k_q     <= '0;
					found_q <= 1'b0;
				end else if (ag_q != LAST_AG) begin
					ag_q <= ag_q + 1'b1;
				end
			end
			// job scan
			if (scan_issue) begin
				k_q <= k_q + 1'b1;
			end
			rd_vld_s1 <= scan_issue;
			if (better) begin
				found_q <= 1'b1;
			end
			// output register
			if (emit) begin
				res_valid_q <= 1'b1;
				ag_q        <= ag_q + 1'b1;
				if (found_q) begin
					job_taken_q[best_q] <= 1'b1;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (job_wr) begin
			pos_x_q[job_in] <= req.job_x;
			pos_y_q[job_in] <= req.job_y;
		end
		if (scan_issue) begin
			k_s1    <= k_q[JIW-1:0];
			elig_s1 <= !job_taken_q[k_q[JIW-1:0]] && known_q[scan_addr];
		end
		if (better) begin
			best_q      <= k_s1;
			best_cost_q <= cost_rd;
		end
		if (emit) begin
			out_agent_q <= IDX_W'(ag_q);
			has_job_q   <= found_q;
			out_job_q   <= found_q ? IDX_W'(best_q) : '0;
			out_x_q     <= found_q ? pos_x_q[best_q] : '0;
			out_y_q     <= found_q ? pos_y_q[best_q] : '0;
			last_q      <= last_agent;
		end
	end

	// result channel
	assign res.valid       = res_valid_q;
	assign res.out_agent   = out_agent_q;
	assign res.has_job     = has_job_q;
	assign res.out_job     = out_job_q;
	assign res.out_x       = out_x_q;
	assign res.out_y       = out_y_q;
	assign res.last_result = last_q;

	// register read
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_LEADER) ? APB_DW'(leader_q) : '0;

`ifndef NO_ASSERTIONS
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !round_open_q)
		else $error("round open during a run");

	a_best_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && found_q) |-> (best_q < job_count_q))
		else $error("chosen job outside the job list");

	a_best_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && found_q) |-> !job_taken_q[best_q])
		else $error("chosen job already taken");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("cost read outside scan");
`endif

endmodule

FILE: tb/sv/greedy_job_assignment_tb.sv
`timescale 1ns / 100ps

module greedy_job_assignment_tb;
	import gja_pkg::*;

	localparam int NA = MAX_AGENTS_DEF;
	localparam int NJ = MAX_JOBS_DEF;
	// settle margin: twice the longest run, over every agent slot and a full job scan per agent
	localparam int SETTLE = 2 * (NA + NA * (NJ + 3));
	localparam int LIMIT = 8 * SETTLE;
	localparam int DIR_ROWS = 23;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] LEADER_ADDR = APB_AW'(4 * REG_LEADER);
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [COST_W-1:0] CMAX = '1;

	typedef struct {
		logic [REQ_W-1:0]        rtype;
		logic [IDX_W-1:0]        agent;
		logic [IDX_W-1:0]        job;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [COST_W-1:0]       cost;
	} req_word_t;

	typedef struct {
		logic [IDX_W-1:0]        agent;
		logic                    has_job;
		logic [IDX_W-1:0]        job;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    last;
	} assign_t;

	// how a directed row is checked
	typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_t;

	typedef struct {
		req_word_t  word;
		row_check_t chk;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	gja_req_if req ();
	gja_res_if res ();

	greedy_job_assignment dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted block state
	logic [COST_W-1:0]       cost_mem [NA*NJ];
	logic [NA*NJ-1:0]        cost_seen;
	logic [NA-1:0]           agent_seen;
	logic signed [POS_W-1:0] job_px [NJ];
	logic signed [POS_W-1:0] job_py [NJ];
	int                      njobs;
	bit                      round_on;
	bit                      leader_on;

	// assignment words still owed by the block, oldest first
	assign_t due_assign [$];

	// slots 0 .. filled-1 hold a position, so a run never reads an empty slot
	int filled;
	int idle_pct;
	int stall_pct;
	int n_err;
	int n_sent;
	int n_runs;
	int n_rounds;
	int n_checked;
	int n_empty;
	int quiet_cycles;

	// for runs with a typed check, agent, job, x and y hold the expected word
	dir_row_t dir_tab [DIR_ROWS] = '{
		// run while no round is open
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, NO_RESULT},
		// unused request code with every field at its top
		'{'{REQ_UNUSED, 4'd15, 4'd15, -24'sd1, -24'sd1, CMAX}, BY_MODEL},
		// round with a single job and a maximal cost
		'{'{REQ_JOB, 4'd0, 4'd0, POS_MIN, POS_MAX, 24'd0}, BY_MODEL},
		'{'{REQ_COST, 4'd0, 4'd0, 24'sd0, 24'sd0, CMAX}, BY_MODEL},
		'{'{REQ_RUN, 4'd0, 4'd0, POS_MIN, POS_MAX, 24'd0}, ONE_RESULT},
		// the run closed the round
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, NO_RESULT},
		// cost and job entries while closed, run still refused
		'{'{REQ_COST, 4'd3, 4'd0, 24'sd0, 24'sd0, 24'd5}, BY_MODEL},
		'{'{REQ_JOB, 4'd0, 4'd1, POS_MAX, POS_MIN, 24'd0}, BY_MODEL},
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, NO_RESULT},
		// three jobs, ties, overwrite, cost outside the job list
		'{'{REQ_JOB, 4'd0, 4'd0, 24'sh000100, -24'sh000100, 24'd0}, BY_MODEL},
		'{'{REQ_JOB, 4'd0, 4'd1, 24'sh123456, 24'sh5A5A5A, 24'd0}, BY_MODEL},
		'{'{REQ_JOB, 4'd0, 4'd2, 24'shA5A5A5, 24'sh000001, 24'd0}, BY_MODEL},
		'{'{REQ_COST, 4'd15, 4'd15, 24'sd0, 24'sd0, 24'd0}, BY_MODEL},
		'{'{REQ_COST, 4'd2, 4'd1, 24'sd0, 24'sd0, 24'd7}, BY_MODEL},
		'{'{REQ_COST, 4'd2, 4'd2, 24'sd0, 24'sd0, 24'd7}, BY_MODEL},
		'{'{REQ_COST, 4'd5, 4'd1, 24'sd0, 24'sd0, 24'd3}, BY_MODEL},
		'{'{REQ_COST, 4'd7, 4'd0, 24'sd0, 24'sd0, 24'd0}, BY_MODEL},
		'{'{REQ_COST, 4'd7, 4'd2, 24'sd0, 24'sd0, 24'd0}, BY_MODEL},
		'{'{REQ_COST, 4'd2, 4'd1, 24'sd0, 24'sd0, 24'd9}, BY_MODEL},
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, BY_MODEL},
		// new round with no agents: closes quietly
		'{'{REQ_JOB, 4'd0, 4'd0, 24'sh0FF000, 24'sh0000FF, 24'd0}, BY_MODEL},
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, NO_RESULT},
		'{'{REQ_RUN, 4'd0, 4'd0, 24'sd0, 24'sd0, 24'd0}, NO_RESULT}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		n_err++;
	endtask

	// greedy assignment predictor, updated on every accepted word
	task automatic plan_request(input req_word_t w);
		logic [NJ-1:0]     taken;
		logic [COST_W-1:0] best_cost;
		int                ag;
		int                k;
		int                best;
		int                top;
		bit                found;
		assign_t           r;
		case (w.rtype)
			REQ_JOB: begin
				// slot 0 opens a new round
				if (w.job == 0) begin
					cost_seen = '0;
					agent_seen = '0;
					njobs = 0;
					round_on = 1'b1;
				end
				job_px[w.job] = w.x;
				job_py[w.job] = w.y;
				if (int'(w.job) + 1 > njobs)
					njobs = int'(w.job) + 1;
			end
			REQ_COST: begin
				cost_mem[{w.agent, w.job}] = w.cost;
				cost_seen[{w.agent, w.job}] = 1'b1;
				agent_seen[w.agent] = 1'b1;
			end
			REQ_RUN: begin
				if (leader_on && round_on) begin
					round_on = 1'b0;
					taken = '0;
					n_runs++;
					top = -1;
					for (ag = 0; ag < NA; ag++)
						if (agent_seen[ag])
							top = ag;
					// agents in index order, cheapest free job, lowest slot on ties
					for (ag = 0; ag < NA; ag++) begin
						if (agent_seen[ag]) begin
							found = 1'b0;
							best = 0;
							best_cost = '0;
							for (k = 0; k < njobs; k++) begin
								if (!taken[k] && cost_seen[ag*NJ + k] &&
									(!found || cost_mem[ag*NJ + k] < best_cost)) begin
									found = 1'b1;
									best = k;
									best_cost = cost_mem[ag*NJ + k];
								end
							end
							r.agent = IDX_W'(ag);
							r.has_job = found;
							r.job = found ? IDX_W'(best) : '0;
							r.x = found ? job_px[best] : '0;
							r.y = found ? job_py[best] : '0;
							r.last = (ag == top);
							if (found)
								taken[best] = 1'b1;
							due_assign.insert(due_assign.size(), r);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// drive one request word, wait for it to be taken, then predict
	task automatic send_req(input req_word_t w, input row_check_t chk);
		int      base;
		assign_t typed;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= w.rtype;
		req.agent_index <= w.agent;
		req.job_index <= w.job;
		req.job_x <= w.x;
		req.job_y <= w.y;
		req.cost_value <= w.cost;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		base = due_assign.size();
		plan_request(w);
		if (chk != BY_MODEL) begin
			while (due_assign.size() > base)
				void'(due_assign.pop_back());
			if (chk == ONE_RESULT) begin
				typed = '{w.agent, 1'b1, w.job, w.x, w.y, 1'b1};
				due_assign.insert(due_assign.size(), typed);
			end
		end
		if (w.rtype != REQ_UNUSED)
			n_sent++;
		if (w.rtype == REQ_JOB && int'(w.job) == filled && filled < NJ)
			filled++;
	endtask

	task automatic req_quiet();
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	// one apb transfer on leader_enable; a read is checked against the shadow
	task automatic apb_access(input bit wr, input bit v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= LEADER_ADDR;
		pwdata <= APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr)
			leader_on = v;
		else if (prdata !== APB_DW'(leader_on))
			note_mismatch("leader_enable read", prdata, APB_DW'(leader_on));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// register change only once the block has drained and settled
	task automatic set_leader(input bit v);
		req_quiet();
		while (due_assign.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		apb_access(1'b0, 1'b0);
		apb_access(1'b1, v);
		apb_access(1'b0, 1'b0);
	endtask

	function automatic req_word_t rand_word(input logic [REQ_W-1:0] kind);
		req_word_t w;
		w.rtype = kind;
		w.agent = IDX_W'($urandom_range(0, NA - 1));
		w.job = IDX_W'($urandom_range(0, NJ - 1));
		w.x = POS_W'($urandom());
		w.y = POS_W'($urandom());
		w.cost = COST_W'($urandom());
		return w;
	endfunction

	// stray word: unused code, early run, loose cost, or a job entry off slot 0
	task automatic noise_req();
		req_word_t w;
		w = rand_word(REQ_UNUSED);
		case ($urandom_range(0, 3))
			0: w.rtype = REQ_UNUSED;
			1: w.rtype = REQ_RUN;
			2: w.rtype = REQ_COST;
			default: begin
				w.rtype = REQ_JOB;
				w.job = IDX_W'($urandom_range(1, (filled < NJ) ? filled : NJ - 1));
			end
		endcase
		send_req(w, BY_MODEL);
	endtask

	// a well-formed round: job list from slot 0, cost entries, run
	task automatic random_round();
		req_word_t w;
		int        njob;
		int        ncost;
		int        na;
		int        base;
		int        i;
		njob = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NJ) : $urandom_range(1, 6);
		ncost = $urandom_range(0, 3 * njob + 3);
		na = $urandom_range(1, NA);
		base = $urandom_range(0, NA - 1);
		for (i = 0; i < njob; i++) begin
			w = rand_word(REQ_JOB);
			w.job = IDX_W'(i);
			send_req(w, BY_MODEL);
			if ($urandom_range(0, 15) == 0)
				noise_req();
		end
		for (i = 0; i < ncost; i++) begin
			w = rand_word(REQ_COST);
			w.agent = IDX_W'((base + $urandom_range(0, na - 1)) % NA);
			if ($urandom_range(0, 7) != 0)
				w.job = IDX_W'($urandom_range(0, njob - 1));
			// small costs make ties common
			case ($urandom_range(0, 7))
				0: w.cost = CMAX;
				1, 2, 3: w.cost = COST_W'($urandom_range(0, 7));
				default: ;
			endcase
			send_req(w, BY_MODEL);
			if ($urandom_range(0, 15) == 0)
				noise_req();
		end
		send_req(rand_word(REQ_RUN), BY_MODEL);
		n_rounds++;
		// now and then hold off until every owed word is back
		if (n_rounds % 4 == 0) begin
			req_quiet();
			while (due_assign.size() != 0)
				@(posedge clk);
		end
		repeat ($urandom_range(0, 2)) noise_req();
	endtask

	task automatic run_phase(input int idle, input int stall, input bit lead, input int items);
		int stop;
		set_leader(lead);
		idle_pct = idle;
		stall_pct = stall;
		stop = n_sent + items;
		while (n_sent < stop)
			random_round();
	endtask

	// result checking and watchdog
	always @(posedge clk) begin : mon
		assign_t want;
		if (res.valid && res.ready) begin
			if (due_assign.size() == 0) begin
				note_mismatch("word with nothing owed, agent", res.out_agent, 0);
			end else begin
				want = due_assign.pop_front();
				n_checked++;
				if (!want.has_job)
					n_empty++;
				if (res.out_agent !== want.agent)
					note_mismatch("out_agent", res.out_agent, want.agent);
				if (res.has_job !== want.has_job)
					note_mismatch("has_job", res.has_job, want.has_job);
				if (res.out_job !== want.job)
					note_mismatch("out_job", res.out_job, want.job);
				if (res.out_x !== want.x)
					note_mismatch("out_x", res.out_x, want.x);
				if (res.out_y !== want.y)
					note_mismatch("out_y", res.out_y, want.y);
				if (res.last_result !== want.last)
					note_mismatch("last_result", res.last_result, want.last);
			end
		end
		if ((req.valid && req.ready) || (res.valid && res.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_JOB;
		req.agent_index = '0;
		req.job_index = '0;
		req.job_x = '0;
		req.job_y = '0;
		req.cost_value = '0;
		cost_seen = '0;
		agent_seen = '0;
		njobs = 0;
		round_on = 1'b0;
		leader_on = 1'b0;
		filled = 0;
		idle_pct = 0;
		stall_pct = 0;
		n_err = 0;
		n_sent = 0;
		n_runs = 0;
		n_rounds = 0;
		n_checked = 0;
		n_empty = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows under leader mode
		set_leader(1'b1);
		for (int i = 0; i < DIR_ROWS; i++)
			send_req(dir_tab[i].word, dir_tab[i].chk);

		// random rounds under each flow-control mix, plus a short stretch as follower
		run_phase(0, 0, 1'b1, 100);
		run_phase(45, 0, 1'b1, 95);
		run_phase(0, 0, 1'b0, 20);
		run_phase(0, 45, 1'b1, 85);
		run_phase(34, 34, 1'b1, 110);

		// drain and let any last run finish
		req_quiet();
		while (due_assign.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d requests in %0d random rounds, leader on and off",
			n_sent, n_rounds);
		$display("%0d runs carried out, %0d assignment words checked, %0d with no job left",
			n_runs, n_checked, n_empty);
		if (n_err == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: greedy_job_assignment.f
rtl/gja_pkg.sv
rtl/gja_req_if.sv
rtl/gja_res_if.sv
rtl/gja_ram.sv
rtl/greedy_job_assignment.sv
tb/sv/greedy_job_assignment_tb.sv
